### rtl/pas_pkg.sv
// ----------------------------------------------------------------------------
// pas_pkg - shared types and constants for polygon area statistics
// Fixed field widths, mode codes, register indexes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int VALUE_WIDTH  = 52;
    localparam int CROSS_WIDTH  = 48;
    localparam int TARGET_WIDTH = 16;
    localparam int MODE_WIDTH   = 4;
    localparam int PSEEN_WIDTH  = 16;
    localparam int CFG_WIDTH    = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = 16'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b1;

    // aggregation modes
    localparam logic [MODE_WIDTH-1:0] MODE_EVEN_SUM  = 4'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_ODD_SUM   = 4'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_MEAN      = 4'd2;
    localparam logic [MODE_WIDTH-1:0] MODE_EXACT_SUM = 4'd3;
    localparam logic [MODE_WIDTH-1:0] MODE_MAX_AREA  = 4'd4;
    localparam logic [MODE_WIDTH-1:0] MODE_MIN_AREA  = 4'd5;
    localparam logic [MODE_WIDTH-1:0] MODE_MAX_VERT  = 4'd6;
    localparam logic [MODE_WIDTH-1:0] MODE_MIN_VERT  = 4'd7;
    localparam logic [MODE_WIDTH-1:0] MODE_EVEN_CNT  = 4'd8;
    localparam logic [MODE_WIDTH-1:0] MODE_ODD_CNT   = 4'd9;
    localparam logic [MODE_WIDTH-1:0] MODE_EXACT_CNT = 4'd10;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture accepted beat
        logic mul_en;      // register the two cross products
        logic mul_close;   // products use current x first instead of prev x current
        logic acc_vertex;  // fold products, advance prev vertex and count
        logic acc_close;   // fold closing products
        logic close_poly;  // fold polygon into set aggregate
        logic div_start;   // launch mean division
        logic emit;        // load result register and clear the set
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_last;
        logic need_div;
        logic out_free;
        logic div_done;
        logic div_busy;
    } sts_t;

endpackage

### rtl/polygon_area_statistics_top.sv
// ----------------------------------------------------------------------------
// polygon_area_statistics_top - shoelace polygon area statistics
// Accumulates twice the area of each polygon and folds it into a per-set
// aggregate chosen by the mode register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per vertex (op = 0) with x, y
//   and last_vertex, or an end-of-set marker (op = 1). Output channel
//   (out_valid/out_ready): one beat per end-of-set marker carrying value
//   (area with one fractional bit, or a count), polygons_seen and status.
//   Config: cfg_we/cfg_addr/cfg_wdata write mode (index 0) and
//   target_vertices (index 1); write only while the block is idle.
// Sequence, from one accept to the next:
//   plain vertex: accept, multiply, accumulate; closing vertex adds the
//   closing multiply, accumulate and the fold into the set aggregate.
//   End marker: the emit step loads the result register; in the mean mode
//   the one-bit-per-cycle restoring divider (52 quotient bits) runs first.
//   out_valid is registered and is set by the emit step.
// Stall: the result register decouples the sides; vertices keep flowing
//   while a result waits. A second end marker holds in the emit step until
//   the pending result is taken.
// Reset: mode 0, target_vertices 3, all polygon and set state cleared, no
//   result pending.
// ----------------------------------------------------------------------------
module polygon_area_statistics_top #(
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [pas_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [pas_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    // vertex / end-of-set beats
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic signed [COORD_WIDTH-1:0]       x,
    input  logic signed [COORD_WIDTH-1:0]       y,
    input  logic                                last_vertex,
    // result beats
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pas_pkg::VALUE_WIDTH-1:0]     value,
    output logic [pas_pkg::PSEEN_WIDTH-1:0]     polygons_seen,
    output logic                                status
);

    import pas_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: owns in_ready and steps each beat through the datapath
    pas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: cross products, saturating sums, aggregate, divider, result reg
    pas_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .x             (x),
        .y             (y),
        .last_vertex   (last_vertex),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .value         (value),
        .polygons_seen (polygons_seen),
        .status        (status)
    );

    // a result is only loaded into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result loaded over a pending beat");

    // the divider only runs for a mean over a non-empty set
    a_div_need: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> sts.need_div)
        else $error("divider started without a divisor");

    // no new beat is taken while the divider is busy
    a_ready_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !sts.div_busy)
        else $error("input ready during division");

    // a vertex beat never produces a result on the next cycle
    a_vertex_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !op) |=> !cmd.emit)
        else $error("vertex beat produced a result");

endmodule

### rtl/pas_div.sv
// ----------------------------------------------------------------------------
// pas_div - restoring divider
// One quotient bit per cycle; done pulses the cycle after the last bit.
// ----------------------------------------------------------------------------
module pas_div #(
    parameter int DIVIDEND_WIDTH = 52,
    parameter int DIVISOR_WIDTH  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVIDEND_WIDTH-1:0] dividend,
    input  logic [DIVISOR_WIDTH-1:0]  divisor,
    output logic                      busy,
    output logic                      done,
    output logic [DIVIDEND_WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_WIDTH - 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          step_reg, step_next;
    logic [DIVISOR_WIDTH-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_WIDTH-1:0] quot_reg, quot_next;
    logic [DIVISOR_WIDTH:0]    rem_sh;
    logic [DIVISOR_WIDTH:0]    rem_diff;
    logic                      fits;

    assign rem_sh   = {rem_reg, quot_reg[DIVIDEND_WIDTH-1]};
    assign fits     = rem_sh >= {1'b0, divisor};
    assign rem_diff = rem_sh - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quot_next = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_diff[DIVISOR_WIDTH-1:0] : rem_sh[DIVISOR_WIDTH-1:0];
            quot_next = {quot_reg[DIVIDEND_WIDTH-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### rtl/pas_dp.sv
// ----------------------------------------------------------------------------
// pas_dp - polygon area datapath
// Config registers, vertex and cross-product registers, set aggregate,
// mean divider and the result register.
// ----------------------------------------------------------------------------
module pas_dp #(
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pas_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [pas_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    input  logic signed [COORD_WIDTH-1:0]       x,
    input  logic signed [COORD_WIDTH-1:0]       y,
    input  logic                                last_vertex,
    input  pas_pkg::cmd_t                       cmd,
    output pas_pkg::sts_t                       sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [pas_pkg::VALUE_WIDTH-1:0]     value,
    output logic [pas_pkg::PSEEN_WIDTH-1:0]     polygons_seen,
    output logic                                status
);

    import pas_pkg::*;

    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int DIFF_W = PROD_W + 1;
    localparam int SUM_W  = ((DIFF_W > CROSS_WIDTH) ? DIFF_W : CROSS_WIDTH) + 1;
    localparam int CMP_W  = (COUNT_WIDTH > TARGET_WIDTH) ? COUNT_WIDTH : TARGET_WIDTH;
    localparam int PS_W   = (COUNT_WIDTH > PSEEN_WIDTH) ? COUNT_WIDTH : PSEEN_WIDTH;

    localparam logic signed [SUM_W-1:0] CROSS_HI_EXT =
        SUM_W'($signed({1'b0, {(CROSS_WIDTH-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] CROSS_LO_EXT =
        SUM_W'($signed({1'b1, {(CROSS_WIDTH-1){1'b0}}}));
    localparam logic [PS_W-1:0] PSEEN_MAX = PS_W'({PSEEN_WIDTH{1'b1}});

    // config
    logic [MODE_WIDTH-1:0]   mode_reg;
    logic [TARGET_WIDTH-1:0] target_reg;

    // captured beat and products
    logic signed [COORD_WIDTH-1:0] x_reg, y_reg;
    logic                          last_reg;
    logic signed [PROD_W-1:0]      prod_a_reg, prod_b_reg;

    // polygon and set state
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [CROSS_WIDTH-1:0] cross_reg;
    logic [COUNT_WIDTH-1:0]        vcount_reg, pcount_reg;
    logic [VALUE_WIDTH-1:0]        total_reg, ext_reg;
    logic                          ext_valid_reg;

    // result register
    logic                          out_valid_reg;
    logic [VALUE_WIDTH-1:0]        value_reg, value_next;
    logic [PSEEN_WIDTH-1:0]        pseen_reg, pseen_next;
    logic                          status_reg, status_next;

    // combinational
    logic signed [COORD_WIDTH-1:0] ax, ay, bx, by;
    logic signed [PROD_W-1:0]      prod_a_next, prod_b_next;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [SUM_W-1:0]       sum;
    logic signed [CROSS_WIDTH-1:0] cross_sat;
    logic [CROSS_WIDTH-1:0]        cross_u, area;
    logic [VALUE_WIDTH-1:0]        area_ext, nvert_ext;
    logic                          even, exact;
    logic                          add_en, ext_en, ext_max;
    logic [VALUE_WIDTH-1:0]        add_val, ext_cand;
    logic [VALUE_WIDTH:0]          total_sum;
    logic [VALUE_WIDTH-1:0]        total_sat;
    logic                          ext_take;
    logic [PS_W-1:0]               ps_ext;
    logic                          div_busy, div_done;
    logic [VALUE_WIDTH-1:0]        quotient;

    // operand select: prev x cur while walking, cur x first when closing
    assign ax = cmd.mul_close ? x_reg       : prev_x_reg;
    assign ay = cmd.mul_close ? y_reg       : prev_y_reg;
    assign bx = cmd.mul_close ? first_x_reg : x_reg;
    assign by = cmd.mul_close ? first_y_reg : y_reg;

    assign prod_a_next = PROD_W'(ax) * PROD_W'(by);
    assign prod_b_next = PROD_W'(ay) * PROD_W'(bx);

    assign diff = DIFF_W'(prod_a_reg) - DIFF_W'(prod_b_reg);
    assign sum  = SUM_W'(cross_reg) + SUM_W'(diff);

    always_comb
    begin
        priority if (sum > CROSS_HI_EXT)
            cross_sat = CROSS_HI_EXT[CROSS_WIDTH-1:0];
        else if (sum < CROSS_LO_EXT)
            cross_sat = CROSS_LO_EXT[CROSS_WIDTH-1:0];
        else
            cross_sat = sum[CROSS_WIDTH-1:0];
    end

    // |cross| is twice the area
    assign cross_u   = cross_reg;
    assign area      = cross_u[CROSS_WIDTH-1] ? (~cross_u + 1'b1) : cross_u;
    assign area_ext  = VALUE_WIDTH'(area);
    assign nvert_ext = VALUE_WIDTH'(vcount_reg);
    assign even      = ~vcount_reg[0];
    assign exact     = CMP_W'(vcount_reg) == CMP_W'(target_reg);

    always_comb
    begin
        add_en   = 1'b0;
        add_val  = area_ext;
        ext_en   = 1'b0;
        ext_max  = 1'b1;
        ext_cand = area_ext;
        unique case (mode_reg)
            MODE_EVEN_SUM:  add_en = even;
            MODE_ODD_SUM:   add_en = ~even;
            MODE_MEAN:      add_en = 1'b1;
            MODE_EXACT_SUM: add_en = exact;
            MODE_MAX_AREA:  ext_en = 1'b1;
            MODE_MIN_AREA:
            begin
                ext_en  = 1'b1;
                ext_max = 1'b0;
            end
            MODE_MAX_VERT:
            begin
                ext_en   = 1'b1;
                ext_cand = nvert_ext;
            end
            MODE_MIN_VERT:
            begin
                ext_en   = 1'b1;
                ext_max  = 1'b0;
                ext_cand = nvert_ext;
            end
            MODE_EVEN_CNT:
            begin
                add_en  = even;
                add_val = VALUE_WIDTH'(1);
            end
            MODE_ODD_CNT:
            begin
                add_en  = ~even;
                add_val = VALUE_WIDTH'(1);
            end
            MODE_EXACT_CNT:
            begin
                add_en  = exact;
                add_val = VALUE_WIDTH'(1);
            end
            default: ;
        endcase
    end

    assign total_sum = {1'b0, total_reg} + {1'b0, add_val};
    assign total_sat = total_sum[VALUE_WIDTH] ? {VALUE_WIDTH{1'b1}} : total_sum[VALUE_WIDTH-1:0];
    assign ext_take  = !ext_valid_reg || (ext_max ? (ext_cand > ext_reg) : (ext_cand < ext_reg));

    // end-of-set answer
    assign ps_ext     = PS_W'(pcount_reg);
    assign pseen_next = (ps_ext > PSEEN_MAX) ? {PSEEN_WIDTH{1'b1}} : ps_ext[PSEEN_WIDTH-1:0];

    always_comb
    begin
        value_next  = '0;
        status_next = STATUS_OK;
        unique case (mode_reg)
            MODE_MEAN:
            begin
                if (pcount_reg == '0)
                    status_next = STATUS_EMPTY;
                else
                    value_next = quotient;
            end
            MODE_MAX_AREA, MODE_MIN_AREA, MODE_MAX_VERT, MODE_MIN_VERT:
            begin
                if (!ext_valid_reg)
                    status_next = STATUS_EMPTY;
                else
                    value_next = ext_reg;
            end
            MODE_EVEN_SUM, MODE_ODD_SUM, MODE_EXACT_SUM,
            MODE_EVEN_CNT, MODE_ODD_CNT, MODE_EXACT_CNT:
                value_next = total_reg;
            default: ;
        endcase
    end

    pas_div #(
        .DIVIDEND_WIDTH (VALUE_WIDTH),
        .DIVISOR_WIDTH  (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (total_reg),
        .divisor  (pcount_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // state with defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_EVEN_SUM;
            target_reg    <= TARGET_RESET;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            cross_reg     <= '0;
            vcount_reg    <= '0;
            pcount_reg    <= '0;
            total_reg     <= '0;
            ext_reg       <= '0;
            ext_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MODE:   mode_reg   <= cfg_wdata[MODE_WIDTH-1:0];
                    REG_TARGET: target_reg <= cfg_wdata[TARGET_WIDTH-1:0];
                endcase
            end

            if (cmd.acc_vertex)
            begin
                if (vcount_reg == '0)
                begin
                    first_x_reg <= x_reg;
                    first_y_reg <= y_reg;
                    cross_reg   <= '0;
                end
                else
                    cross_reg <= cross_sat;
                prev_x_reg <= x_reg;
                prev_y_reg <= y_reg;
                if (vcount_reg != {COUNT_WIDTH{1'b1}})
                    vcount_reg <= vcount_reg + 1'b1;
            end

            if (cmd.acc_close)
                cross_reg <= cross_sat;

            if (cmd.close_poly)
            begin
                if (pcount_reg != {COUNT_WIDTH{1'b1}})
                    pcount_reg <= pcount_reg + 1'b1;
                if (add_en)
                    total_reg <= total_sat;
                if (ext_en)
                begin
                    ext_valid_reg <= 1'b1;
                    if (ext_take)
                        ext_reg <= ext_cand;
                end
                cross_reg  <= '0;
                vcount_reg <= '0;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                cross_reg     <= '0;
                vcount_reg    <= '0;
                pcount_reg    <= '0;
                total_reg     <= '0;
                ext_reg       <= '0;
                ext_valid_reg <= 1'b0;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            x_reg    <= x;
            y_reg    <= y;
            last_reg <= last_vertex;
        end
        if (cmd.mul_en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (cmd.emit)
        begin
            value_reg  <= value_next;
            pseen_reg  <= pseen_next;
            status_reg <= status_next;
        end
    end

    assign sts.item_last = last_reg;
    assign sts.need_div  = (mode_reg == MODE_MEAN) && (pcount_reg != '0);
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.div_done  = div_done;
    assign sts.div_busy  = div_busy;

    assign out_valid     = out_valid_reg;
    assign value         = value_reg;
    assign polygons_seen = pseen_reg;
    assign status        = status_reg;

endmodule

### rtl/pas_ctrl.sv
// ----------------------------------------------------------------------------
// pas_ctrl - sequencer for polygon area statistics
// Steps each beat through multiply, accumulate, close, divide and emit.
// ----------------------------------------------------------------------------
module pas_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          op,
    output logic          in_ready,
    input  pas_pkg::sts_t sts,
    output pas_pkg::cmd_t cmd
);

    import pas_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_ACC   = 8'b0000_0100,
        ST_MUL_C = 8'b0000_1000,
        ST_ACC_C = 8'b0001_0000,
        ST_CLOSE = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (!op)
                        state_next = ST_MUL;
                    else if (sts.need_div)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_vertex = 1'b1;
                state_next     = sts.item_last ? ST_MUL_C : ST_IDLE;
            end
            ST_MUL_C:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_close = 1'b1;
                state_next    = ST_ACC_C;
            end
            ST_ACC_C:
            begin
                cmd.acc_close = 1'b1;
                state_next    = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                cmd.close_poly = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### verif/polygon_area_statistics_checker.sv
// ----------------------------------------------------------------------------
// polygon_area_statistics_checker - result predictor and scoreboard
// Watches the register port and both beat channels of the polygon area
// statistics block, keeps its own copy of polygon and set state, and checks
// every result beat against the oldest predicted set result.
// ----------------------------------------------------------------------------
package pas_beat_pkg;

    // op field of an input beat
    localparam logic OP_VERTEX  = 1'b0;
    localparam logic OP_SET_END = 1'b1;

endpackage

module polygon_area_statistics_checker #(
    parameter int COORD_WIDTH = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pas_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [pas_pkg::CFG_WIDTH-1:0]       cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                op,
    input  logic signed [COORD_WIDTH-1:0]       x,
    input  logic signed [COORD_WIDTH-1:0]       y,
    input  logic                                last_vertex,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [pas_pkg::VALUE_WIDTH-1:0]     value,
    input  logic [pas_pkg::PSEEN_WIDTH-1:0]     polygons_seen,
    input  logic                                status,
    output int                                  mismatches,
    output int                                  results_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import pas_pkg::*;
    import pas_beat_pkg::*;

    localparam longint CROSS_HI = (64'sd1 <<< (CROSS_WIDTH - 1)) - 64'sd1;
    localparam longint CROSS_LO = -CROSS_HI - 64'sd1;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [PSEEN_WIDTH-1:0] seen;
        logic                   status;
    } set_result_t;

    set_result_t expected_set_results[$];

    // predicted block state
    logic [MODE_WIDTH-1:0]          cur_mode;
    logic [TARGET_WIDTH-1:0]        cur_target;
    logic signed [COORD_WIDTH-1:0]  first_x, first_y, prev_x, prev_y;
    logic signed [CROSS_WIDTH-1:0]  cross_acc;
    logic [COUNT_WIDTH-1:0]         vtx_count;
    logic [COUNT_WIDTH-1:0]         poly_count;
    logic [VALUE_WIDTH-1:0]         set_sum;
    logic [VALUE_WIDTH-1:0]         extreme;
    logic                           extreme_seen;

    function automatic logic signed [CROSS_WIDTH-1:0] cross_step(
        input logic signed [CROSS_WIDTH-1:0] acc,
        input logic signed [COORD_WIDTH-1:0] ax, ay, bx, by
    );
        longint s;
        s = longint'(acc) + longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
        if (s > CROSS_HI)
            s = CROSS_HI;
        else if (s < CROSS_LO)
            s = CROSS_LO;
        return CROSS_WIDTH'(s);
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] sat_add(
        input logic [VALUE_WIDTH-1:0] a,
        input logic [VALUE_WIDTH-1:0] b
    );
        logic [VALUE_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VALUE_WIDTH] ? '1 : s[VALUE_WIDTH-1:0];
    endfunction

    task automatic pick_extreme(input logic [VALUE_WIDTH-1:0] v, input logic want_max);
        if (!extreme_seen || (want_max ? v > extreme : v < extreme))
            extreme = v;
        extreme_seen = 1'b1;
    endtask

    task automatic clear_polygon();
        cross_acc = '0;
        vtx_count = '0;
    endtask

    task automatic clear_set();
        clear_polygon();
        set_sum      = '0;
        poly_count   = '0;
        extreme      = '0;
        extreme_seen = 1'b0;
    endtask

    // fold the closed polygon into the set by the mode in force now
    task automatic fold_polygon();
        longint                 s;
        logic [VALUE_WIDTH-1:0] area2;
        logic                   even, exact;
        s     = longint'(cross_acc);
        area2 = VALUE_WIDTH'(s < 0 ? -s : s);
        even  = ~vtx_count[0];
        exact = (vtx_count == cur_target);
        if (poly_count != '1)
            poly_count++;
        case (cur_mode)
            MODE_EVEN_SUM:  if (even) set_sum = sat_add(set_sum, area2);
            MODE_ODD_SUM:   if (!even) set_sum = sat_add(set_sum, area2);
            MODE_MEAN:      set_sum = sat_add(set_sum, area2);
            MODE_EXACT_SUM: if (exact) set_sum = sat_add(set_sum, area2);
            MODE_MAX_AREA:  pick_extreme(area2, 1'b1);
            MODE_MIN_AREA:  pick_extreme(area2, 1'b0);
            MODE_MAX_VERT:  pick_extreme(VALUE_WIDTH'(vtx_count), 1'b1);
            MODE_MIN_VERT:  pick_extreme(VALUE_WIDTH'(vtx_count), 1'b0);
            MODE_EVEN_CNT:  if (even) set_sum = sat_add(set_sum, VALUE_WIDTH'(1));
            MODE_ODD_CNT:   if (!even) set_sum = sat_add(set_sum, VALUE_WIDTH'(1));
            MODE_EXACT_CNT: if (exact) set_sum = sat_add(set_sum, VALUE_WIDTH'(1));
            default: ;
        endcase
        clear_polygon();
    endtask

    task automatic take_vertex(
        input logic signed [COORD_WIDTH-1:0] vx, vy,
        input logic                          closes
    );
        if (vtx_count == '0)
        begin
            first_x   = vx;
            first_y   = vy;
            cross_acc = '0;
        end
        else
        begin
            cross_acc = cross_step(cross_acc, prev_x, prev_y, vx, vy);
        end
        prev_x = vx;
        prev_y = vy;
        if (vtx_count != '1)
            vtx_count++;
        if (closes)
        begin
            cross_acc = cross_step(cross_acc, vx, vy, first_x, first_y);
            fold_polygon();
        end
    endtask

    task automatic close_set();
        set_result_t r;
        r      = '0;
        r.seen = PSEEN_WIDTH'(poly_count);
        case (cur_mode)
            MODE_MEAN:
                if (poly_count == '0)
                    r.status = STATUS_EMPTY;
                else
                    r.value = set_sum / VALUE_WIDTH'(poly_count);
            MODE_MAX_AREA, MODE_MIN_AREA, MODE_MAX_VERT, MODE_MIN_VERT:
                if (!extreme_seen)
                    r.status = STATUS_EMPTY;
                else
                    r.value = extreme;
            MODE_EVEN_SUM, MODE_ODD_SUM, MODE_EXACT_SUM,
            MODE_EVEN_CNT, MODE_ODD_CNT, MODE_EXACT_CNT:
                r.value = set_sum;
            default: ;
        endcase
        expected_set_results.insert(expected_set_results.size(), r);
        clear_set();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        set_result_t want;
        if (expected_set_results.size() == 0)
        begin
            report_mismatch("result beat with no set end pending", 64'(value), '0);
        end
        else
        begin
            want = expected_set_results.pop_front();
            if (value !== want.value)
                report_mismatch("value", 64'(value), 64'(want.value));
            if (polygons_seen !== want.seen)
                report_mismatch("polygons_seen", 64'(polygons_seen), 64'(want.seen));
            if (status !== want.status)
                report_mismatch("status", 64'(status), 64'(want.status));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode     = MODE_EVEN_SUM;
            cur_target   = TARGET_RESET;
            first_x      = '0;
            first_y      = '0;
            prev_x       = '0;
            prev_y       = '0;
            clear_set();
            expected_set_results.delete();
            results_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MODE:   cur_mode   = cfg_wdata[MODE_WIDTH-1:0];
                    REG_TARGET: cur_target = cfg_wdata[TARGET_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (op == OP_SET_END)
                    close_set();
                else
                    take_vertex(x, y, last_vertex);
            end
            results_pending <= expected_set_results.size();
        end
    end

endmodule

### verif/polygon_area_statistics_top_test.sv
// ----------------------------------------------------------------------------
// polygon_area_statistics_top_test - stimulus and verdict
// Drives vertex and set-end beats with random gaps and output stalls,
// sweeps every mode code and the target register, and covers range-end
// coordinates, degenerate and unfinished polygons and empty sets. The checker
// beside the block predicts and compares; this module only feeds it and reports.
// ----------------------------------------------------------------------------
module polygon_area_statistics_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pas_pkg::*;
    import pas_beat_pkg::*;

    localparam int COORD_WIDTH   = 16;
    localparam int COUNT_WIDTH   = 16;
    localparam int RANDOM_ITEMS  = 1900;
    // settle margin for a mean-mode division at a set end, plus a receiver stall
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;

    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]               cfg_addr    = REG_MODE;
    logic [CFG_WIDTH-1:0]               cfg_wdata   = '0;
    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    logic                               op          = OP_VERTEX;
    logic signed [COORD_WIDTH-1:0]      x           = '0;
    logic signed [COORD_WIDTH-1:0]      y           = '0;
    logic                               last_vertex = 1'b0;
    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic [VALUE_WIDTH-1:0]             value;
    logic [PSEEN_WIDTH-1:0]             polygons_seen;
    logic                               status;

    int mismatches;
    int results_pending;

    // longest wait either side draws before its next beat; 0 gives
    // back-to-back traffic
    int idle_max = 4;
    int vertex_beats   = 0;
    int set_end_beats  = 0;
    int reg_settings   = 0;
    int stall_cycles   = 0;

    always #2 clk = ~clk;

    polygon_area_statistics_top #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .x             (x),
        .y             (y),
        .last_vertex   (last_vertex),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value         (value),
        .polygons_seen (polygons_seen),
        .status        (status)
    );

    polygon_area_statistics_checker #(
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .x               (x),
        .y               (y),
        .last_vertex     (last_vertex),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value           (value),
        .polygons_seen   (polygons_seen),
        .status          (status),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // Watchdog: any accepted beat or register write counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                         stall_cycles, results_pending);
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Result receiver: draws a stall before each beat. With no stall the
    // ready line simply stays high, so it is never dropped and raised in
    // the same step.
    initial
    begin
        int pause;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pause = $urandom_range(0, idle_max);
            if (pause > 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // One input beat. Returns in the step of the edge that accepted it,
    // with valid still high, so the next call can keep the line up.
    task automatic send_beat(input logic b_op, input logic signed [COORD_WIDTH-1:0] bx,
                             input logic signed [COORD_WIDTH-1:0] by, input logic b_last);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= b_op;
        x           <= bx;
        y           <= by;
        last_vertex <= b_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (b_op == OP_SET_END)
            set_end_beats++;
        else
            vertex_beats++;
    endtask

    // Coordinates: range ends, small values near the origin (so areas
    // repeat and ties show up), or anything at all.
    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        logic signed [COORD_WIDTH-1:0] c;
        case ($urandom_range(0, 3))
            0:       c = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1:       c = COORD_WIDTH'($urandom_range(0, 40)) - 16'sd20;
            default: c = COORD_WIDTH'($urandom);
        endcase
        return c;
    endfunction

    // x, y and last_vertex are don't-care on a set end; randomize them
    task automatic send_set_end();
        send_beat(OP_SET_END, COORD_WIDTH'($urandom), COORD_WIDTH'($urandom), 1'($urandom));
    endtask

    task automatic send_polygon(input int nv, input logic closed);
        for (int i = 0; i < nv; i++)
            send_beat(OP_VERTEX, rand_coord(), rand_coord(), closed && (i == nv - 1));
    endtask

    // Walk the four corners of the full coordinate square; each step adds
    // close to 2^31 to the cross sum, with its sign set by the direction.
    task automatic send_corner_walk(input int nv, input logic ccw);
        int k;
        for (int i = 0; i < nv; i++)
        begin
            k = ccw ? (i % 4) : (3 - (i % 4));
            send_beat(OP_VERTEX,
                      (k == 1 || k == 2) ? 16'sh7FFF : 16'sh8000,
                      (k >= 2) ? 16'sh7FFF : 16'sh8000,
                      i == nv - 1);
        end
    endtask

    // Let every predicted result drain, then give the block time to finish
    // a closing fold or a division that produces nothing visible.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers in one burst, only while the block is idle.
    task automatic program_regs(input logic [MODE_WIDTH-1:0] m,
                                input logic [TARGET_WIDTH-1:0] tgt);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MODE;
        cfg_wdata <= CFG_WIDTH'(m);
        @(posedge clk);
        cfg_addr  <= REG_TARGET;
        cfg_wdata <= CFG_WIDTH'(tgt);
        @(posedge clk);
        cfg_we    <= 1'b0;
        reg_settings++;
    endtask

    initial
    begin
        int                      items;
        int                      phase;
        int                      nv;
        logic [MODE_WIDTH-1:0]   m;
        logic [TARGET_WIDTH-1:0] tgt;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset settings (even-vertex area sum, target 3) ----
        idle_max = 2;
        send_set_end();                                   // empty set
        send_corner_walk(4, 1'b1);                        // full-range square
        send_beat(OP_VERTEX, 16'sd0,   16'sd0,   1'b0);   // clockwise triangle
        send_beat(OP_VERTEX, 16'sd0,   16'sd100, 1'b0);
        send_beat(OP_VERTEX, 16'sd100, 16'sd0,   1'b1);
        send_beat(OP_VERTEX, 16'sh7FFF, 16'sh8000, 1'b1); // single vertex
        send_beat(OP_VERTEX, 16'sh8000, 16'sh7FFF, 1'b0); // two vertices
        send_beat(OP_VERTEX, 16'sh7FFF, 16'sh8000, 1'b1);
        send_beat(OP_VERTEX, 16'sd7,   -16'sd9,  1'b0);   // left open
        send_beat(OP_VERTEX, -16'sd3,  16'sd12,  1'b0);
        send_set_end();

        // Polygon folded under a sum mode, then the set closed under max
        // area: the extreme was never written, so the set reads as empty.
        send_beat(OP_VERTEX, -16'sd5, -16'sd5, 1'b0);
        send_beat(OP_VERTEX, 16'sd5,  -16'sd5, 1'b0);
        send_beat(OP_VERTEX, 16'sd0,  16'sd5,  1'b1);
        drain_results();
        program_regs(MODE_MAX_AREA, TARGET_RESET);
        send_set_end();

        // Small triangle under max, larger one under min, one set.
        send_beat(OP_VERTEX, 16'sd0, 16'sd0, 1'b0);
        send_beat(OP_VERTEX, 16'sd2, 16'sd0, 1'b0);
        send_beat(OP_VERTEX, 16'sd0, 16'sd2, 1'b1);
        drain_results();
        program_regs(MODE_MIN_AREA, TARGET_RESET);
        send_beat(OP_VERTEX, 16'sd0,  16'sd0, 1'b0);
        send_beat(OP_VERTEX, 16'sd40, 16'sd0, 1'b0);
        send_beat(OP_VERTEX, 16'sd0,  16'sd40, 1'b1);
        send_set_end();
        drain_results();

        // ---- random phases: every mode code first, then random ones ----
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS)
        begin
            m = (phase < 16) ? MODE_WIDTH'(phase) : MODE_WIDTH'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:       tgt = TARGET_RESET;
                1:       tgt = '1;
                default: tgt = TARGET_WIDTH'($urandom_range(3, 8));
            endcase
            // about a quarter of the phases run with no idling at all
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
            program_regs(m, tgt);

            send_set_end();                    // each mode also sees an empty set
            items++;
            repeat ($urandom_range(4, 10))
            begin
                repeat ($urandom_range(0, 4))
                begin
                    nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2)
                                                     : $urandom_range(3, 7);
                    send_polygon(nv, 1'b1);
                    items += nv;
                end
                if ($urandom_range(0, 5) == 0)
                begin
                    // unfinished polygon, dropped at the set end
                    nv = $urandom_range(1, 3);
                    send_polygon(nv, 1'b0);
                    items += nv;
                end
                send_set_end();
                items++;
            end
            drain_results();
            phase++;
        end

        $display("Covered %0d vertex beats and %0d set-end beats over %0d register settings,",
                 vertex_beats, set_end_beats, reg_settings);
        $display("all sixteen mode codes, empty sets, open and degenerate polygons, stalls.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
